// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define TXY_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define TXY_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/txy_pkg.sv -----
`timescale 1ns / 1ps
package txy_pkg;

  localparam int RING_DEPTH    = 16;
  localparam int SAMPLE_BITS   = 12;
  localparam int RING_IDX_BITS = $clog2(RING_DEPTH);
  localparam int SUM_BITS      = SAMPLE_BITS + RING_IDX_BITS;
  localparam int AVG_BITS      = SAMPLE_BITS;
  localparam int SIZE_BITS     = 11;
  localparam int PROD_BITS     = AVG_BITS + SIZE_BITS;
  localparam int QUOT_BITS     = SIZE_BITS;
  localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS);
  localparam int PIXEL_Y_BITS  = 10;
  localparam int REG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int JOBQ_DEPTH    = 2;
  localparam int JOBQ_PTR_BITS = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CNT_BITS = $clog2(JOBQ_DEPTH + 1);

  localparam logic [REG_IDX_BITS-1:0] REG_X_LO   = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_X_HI   = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_Y_LO   = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_Y_HI   = REG_IDX_BITS'(3);
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = REG_IDX_BITS'(4);
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = REG_IDX_BITS'(5);

  localparam logic [AVG_BITS-1:0]  RST_X_LO   = AVG_BITS'(1500);
  localparam logic [AVG_BITS-1:0]  RST_X_HI   = AVG_BITS'(3500);
  localparam logic [AVG_BITS-1:0]  RST_Y_LO   = AVG_BITS'(1700);
  localparam logic [AVG_BITS-1:0]  RST_Y_HI   = AVG_BITS'(2600);
  localparam logic [SIZE_BITS-1:0] RST_WIDTH  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] RST_HEIGHT = SIZE_BITS'(480);

  typedef struct packed {
    logic [AVG_BITS-1:0]  x_lo;
    logic [AVG_BITS-1:0]  x_hi;
    logic [AVG_BITS-1:0]  y_lo;
    logic [AVG_BITS-1:0]  y_hi;
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic                 axis;
    logic [AVG_BITS-1:0]  x_avg;
    logic [AVG_BITS-1:0]  y_avg;
    logic                 valid;
    logic [SIZE_BITS-1:0] width;
    logic [PROD_BITS-1:0] x_num;
    logic [AVG_BITS-1:0]  x_den;
    logic [PROD_BITS-1:0] y_num;
    logic [AVG_BITS-1:0]  y_den;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } back_state_t;

endpackage

// ----- rtl/txy_front.sv -----
`timescale 1ns / 1ps
module txy_front import txy_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  output logic                   job_push,
  output job_t                   job,
  input  logic                   job_full
);

  logic [SAMPLE_BITS-1:0]   x_ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0]   y_ring [RING_DEPTH];
  logic [RING_DEPTH-1:0]    x_vld;
  logic [RING_DEPTH-1:0]    y_vld;
  logic [RING_IDX_BITS-1:0] x_slot;
  logic [RING_IDX_BITS-1:0] y_slot;
  logic [SUM_BITS-1:0]      x_sum;
  logic [SUM_BITS-1:0]      y_sum;
  logic                     next_is_x;
  logic                     pend;
  logic                     pend_axis;

  logic                     accept;
  logic [SAMPLE_BITS-1:0]   x_old;
  logic [SAMPLE_BITS-1:0]   y_old;
  logic [RING_IDX_BITS-1:0] x_slot_next;
  logic [RING_IDX_BITS-1:0] y_slot_next;
  logic [AVG_BITS-1:0]      x_avg;
  logic [AVG_BITS-1:0]      y_avg;
  logic                     x_in;
  logic                     y_in;
  logic [AVG_BITS-1:0]      x_off;
  logic [AVG_BITS-1:0]      y_off;

  assign full   = pend;
  assign accept = push & ~full;

  // entries never written read as zero
  assign x_old = x_vld[x_slot] ? x_ring[x_slot] : '0;
  assign y_old = y_vld[y_slot] ? y_ring[y_slot] : '0;

  assign x_slot_next = (x_slot == RING_IDX_BITS'(RING_DEPTH - 1)) ? '0 : x_slot + 1'b1;
  assign y_slot_next = (y_slot == RING_IDX_BITS'(RING_DEPTH - 1)) ? '0 : y_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld     <= '0;
      y_vld     <= '0;
      x_slot    <= '0;
      y_slot    <= '0;
      x_sum     <= '0;
      y_sum     <= '0;
      next_is_x <= 1'b0;
      pend      <= 1'b0;
      pend_axis <= 1'b0;
    end else if (accept) begin
      if (next_is_x) begin
        x_vld[x_slot] <= 1'b1;
        x_slot        <= x_slot_next;
        x_sum         <= x_sum - SUM_BITS'(x_old) + SUM_BITS'(adc_sample);
      end else begin
        y_vld[y_slot] <= 1'b1;
        y_slot        <= y_slot_next;
        y_sum         <= y_sum - SUM_BITS'(y_old) + SUM_BITS'(adc_sample);
      end
      next_is_x <= ~next_is_x;
      pend      <= 1'b1;
      pend_axis <= next_is_x;
    end else if (job_push) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (next_is_x) begin
        x_ring[x_slot] <= adc_sample;
      end else begin
        y_ring[y_slot] <= adc_sample;
      end
    end
  end

  // classify the sums left by the last beat and form the scaled numerators
  assign x_avg = x_sum[SUM_BITS-1:RING_IDX_BITS];
  assign y_avg = y_sum[SUM_BITS-1:RING_IDX_BITS];
  assign x_in  = (x_avg > cfg.x_lo) && (x_avg < cfg.x_hi);
  assign y_in  = (y_avg > cfg.y_lo) && (y_avg < cfg.y_hi);
  assign x_off = x_avg - cfg.x_lo;
  assign y_off = y_avg - cfg.y_lo;

  assign job_push = pend & ~job_full;

  always_comb begin
    job.axis  = pend_axis;
    job.x_avg = x_avg;
    job.y_avg = y_avg;
    job.valid = x_in & y_in;
    job.width = cfg.width;
    job.x_num = PROD_BITS'(x_off) * PROD_BITS'(cfg.width);
    job.x_den = cfg.x_hi - cfg.x_lo;
    job.y_num = PROD_BITS'(y_off) * PROD_BITS'(cfg.height);
    job.y_den = cfg.y_hi - cfg.y_lo;
  end

endmodule

// ----- rtl/txy_fifo.sv -----
`timescale 1ns / 1ps
module txy_fifo import txy_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t                     mem [JOBQ_DEPTH];
  logic [JOBQ_PTR_BITS-1:0] wr_ptr;
  logic [JOBQ_PTR_BITS-1:0] rd_ptr;
  logic [JOBQ_CNT_BITS-1:0] count;
  logic                     do_push;
  logic                     do_pop;

  assign full    = (count == JOBQ_CNT_BITS'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- rtl/txy_back.sv -----
`timescale 1ns / 1ps
module txy_back import txy_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    q_job,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic                    axis_updated,
  output logic [AVG_BITS-1:0]     x_average,
  output logic [AVG_BITS-1:0]     y_average,
  output logic                    point_valid,
  output logic [SIZE_BITS-1:0]    pixel_x,
  output logic [PIXEL_Y_BITS-1:0] pixel_y
);

  back_state_t state;
  back_state_t state_next;

  job_t                    job_r;
  logic [AVG_BITS-1:0]     rem;
  logic [QUOT_BITS-1:0]    dq;
  logic [AVG_BITS-1:0]     div;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [QUOT_BITS-1:0]    x_quot;
  logic                    out_valid;

  logic                    ld_x;
  logic                    ld_y;
  logic                    step;
  logic                    out_wr;
  logic                    out_free;
  logic                    last;
  logic [AVG_BITS:0]       trial;
  logic [AVG_BITS:0]       diff;
  logic                    fits;
  logic [AVG_BITS-1:0]     rem_step;
  logic [QUOT_BITS-1:0]    dq_step;

  // restoring divide, one quotient bit a cycle; dq holds the numerator's
  // low bits and collects the quotient behind them
  assign trial    = {rem, dq[QUOT_BITS-1]};
  assign fits     = trial >= {1'b0, div};
  assign diff     = trial - {1'b0, div};
  assign rem_step = fits ? diff[AVG_BITS-1:0] : trial[AVG_BITS-1:0];
  assign dq_step  = {dq[QUOT_BITS-2:0], fits};
  assign last     = (cnt == DIV_CNT_BITS'(QUOT_BITS - 1));
  assign out_free = ~out_valid | pop;
  assign empty    = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_job.valid ? ST_DIV_X : ST_DONE;
        end
      end
      ST_DIV_X: begin
        if (last) begin
          state_next = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    ld_x   = 1'b0;
    ld_y   = 1'b0;
    step   = 1'b0;
    out_wr = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = ~q_empty;
        ld_x  = ~q_empty;
      end
      ST_DIV_X: begin
        step = 1'b1;
        ld_y = last;
      end
      ST_DIV_Y: begin
        step = 1'b1;
      end
      ST_DONE: begin
        out_wr = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // quotients stay below the screen size, so the top bits of the
  // numerator already lie below the divisor
  always_ff @(posedge clk) begin
    if (ld_x) begin
      job_r <= q_job;
      rem   <= q_job.x_num[PROD_BITS-1:QUOT_BITS];
      dq    <= q_job.x_num[QUOT_BITS-1:0];
      div   <= q_job.x_den;
      cnt   <= '0;
    end else if (ld_y) begin
      x_quot <= dq_step;
      rem    <= job_r.y_num[PROD_BITS-1:QUOT_BITS];
      dq     <= job_r.y_num[QUOT_BITS-1:0];
      div    <= job_r.y_den;
      cnt    <= '0;
    end else if (step) begin
      rem <= rem_step;
      dq  <= dq_step;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_wr) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      axis_updated <= job_r.axis;
      x_average    <= job_r.x_avg;
      y_average    <= job_r.y_avg;
      point_valid  <= job_r.valid;
      pixel_x      <= job_r.valid ? job_r.width - x_quot : '0;
      pixel_y      <= job_r.valid ? dq[PIXEL_Y_BITS-1:0] : '0;
    end
  end

endmodule

// ----- rtl/touch_xy_average_and_scale.sv -----
`timescale 1ns / 1ps
// Touchscreen averager and scaler. Samples alternate Y, X, Y, ... from reset;
// each feeds a 16-deep ring per axis whose running sum gives the average, and
// every sample yields one result beat with both averages and, when both lie
// strictly inside their windows, the mirrored X and plain Y pixel position.
// The front takes no new sample until the last point has gone to a two-entry
// job queue. The back works one job at a time through a single shared
// restoring divider, one quotient bit a cycle: a valid point goes through
// fetch, X divide, Y divide and store, an invalid one skips the divides,
// and no job is fetched before the last is stored. Ring valid flags, sums
// and the axis toggle clear at reset. The user must see that configuration
// is written through the cfg port while no sample is in flight; unchecked.
module touch_xy_average_and_scale import txy_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [REG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic [SAMPLE_BITS-1:0]   adc_sample,
  output logic                     empty,
  input  logic                     pop,
  output logic                     axis_updated,
  output logic [AVG_BITS-1:0]      x_average,
  output logic [AVG_BITS-1:0]      y_average,
  output logic                     point_valid,
  output logic [SIZE_BITS-1:0]     pixel_x,
  output logic [PIXEL_Y_BITS-1:0]  pixel_y
);

  cfg_t cfg;
  job_t front_job;
  job_t q_job;
  logic job_push;
  logic job_full;
  logic q_pop;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_lo   <= RST_X_LO;
      cfg.x_hi   <= RST_X_HI;
      cfg.y_lo   <= RST_Y_LO;
      cfg.y_hi   <= RST_Y_HI;
      cfg.width  <= RST_WIDTH;
      cfg.height <= RST_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_LO:   cfg.x_lo   <= cfg_data[AVG_BITS-1:0];
        REG_X_HI:   cfg.x_hi   <= cfg_data[AVG_BITS-1:0];
        REG_Y_LO:   cfg.y_lo   <= cfg_data[AVG_BITS-1:0];
        REG_Y_HI:   cfg.y_hi   <= cfg_data[AVG_BITS-1:0];
        REG_WIDTH:  cfg.width  <= cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  txy_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .adc_sample (adc_sample),
    .job_push   (job_push),
    .job        (front_job),
    .job_full   (job_full)
  );

  txy_fifo u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (front_job),
    .full  (job_full),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  txy_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_job        (q_job),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .axis_updated (axis_updated),
    .x_average    (x_average),
    .y_average    (y_average),
    .point_valid  (point_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y)
  );

endmodule

// ----- rtl/txy_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module txy_checker import txy_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_write,
  input logic [REG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data,
  input logic                     push,
  input logic                     full,
  input logic [SAMPLE_BITS-1:0]   adc_sample,
  input logic                     empty,
  input logic                     pop,
  input logic                     axis_updated,
  input logic [AVG_BITS-1:0]      x_average,
  input logic [AVG_BITS-1:0]      y_average,
  input logic                     point_valid,
  input logic [SIZE_BITS-1:0]     pixel_x,
  input logic [PIXEL_Y_BITS-1:0]  pixel_y
);

  // reset leaves nothing pending on either side
  `TXY_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> empty && !full, "queue not idle after reset")

  // a waiting result beat holds until taken
  `TXY_ASSERT(a_result_hold, clk, rst, !empty && !pop |=> !empty && $stable(x_average) && $stable(pixel_x) && $stable(pixel_y), "stalled result changed")

  // points outside the windows carry zero pixels
  `TXY_ASSERT(a_invalid_zero, clk, rst, !empty && !point_valid |-> pixel_x == '0 && pixel_y == '0, "pixels set on invalid point")

  // the front classifies a sample before it takes the next one
  `TXY_ASSERT(a_front_busy, clk, rst, push && !full |=> full, "front took two samples back to back")

endmodule

bind touch_xy_average_and_scale txy_checker u_txy_checker (.*);
